>>> sv/perm_unrk_pkg.sv
// Package: types, widths and the factorial table for the permutation unranking core.
`timescale 1ns / 1ps

package perm_unrk_pkg;

    localparam int MAX_ELEMENTS = 12;
    localparam int COUNT_W      = 4;
    localparam int RANK_W       = 29;
    localparam int ELEM_W       = 4;
    // quotient per position never exceeds MAX_ELEMENTS - 1
    localparam int QUOT_W       = $clog2(MAX_ELEMENTS);
    localparam int BIT_W        = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;
    localparam int TRIAL_W      = RANK_W + QUOT_W;

    typedef struct packed {
        logic [COUNT_W-1:0] element_count;
        logic [RANK_W-1:0]  rank;
    } in_item_t;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              last;
        logic              rank_error;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PICK,
        ST_ERR
    } unrk_state_t;

    // n! for n up to MAX_ELEMENTS, 0 for counts beyond the table
    function automatic logic [63:0] fact_f(input logic [COUNT_W-1:0] n);
        logic [63:0] res;
        case (n)
            COUNT_W'(0):  res = 64'd1;
            COUNT_W'(1):  res = 64'd1;
            COUNT_W'(2):  res = 64'd2;
            COUNT_W'(3):  res = 64'd6;
            COUNT_W'(4):  res = 64'd24;
            COUNT_W'(5):  res = 64'd120;
            COUNT_W'(6):  res = 64'd720;
            COUNT_W'(7):  res = 64'd5040;
            COUNT_W'(8):  res = 64'd40320;
            COUNT_W'(9):  res = 64'd362880;
            COUNT_W'(10): res = 64'd3628800;
            COUNT_W'(11): res = 64'd39916800;
            COUNT_W'(12): res = 64'd479001600;
            default:      res = 64'd0;
        endcase
        return res;
    endfunction

endpackage

>>> sv/permutation_unrank_core.sv
// Top level: permutation unranking by the factorial number system.
`timescale 1ns / 1ps

//  channel | direction | payload     | handshake
//  --------+-----------+-------------+---------------------
//  s_      | in        | in_item_t   | s_valid / s_ready
//  m_      | out       | out_item_t  | m_valid / m_ready
//
//  A request is accepted while idle; then per element one restoring division of the
//  remaining rank by (n-i)! runs through a single compare-subtract unit over the quotient
//  bits that n-i needs, highest first, plus a pick step that takes the element from the
//  used mask. A rejected request yields a single output item with last and rank_error set.
//  Reset (aresetn low, synchronous) returns the sequencer to idle and drops any pending transfer.
//  A stalled result waits in the output register; the divider runs ahead and holds in the pick
//  step until that register frees up. s_ready is high only while idle.
module permutation_unrank_core
    import perm_unrk_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // highest set bit of r: the top quotient bit that can be non-zero when the quotient <= r
    function automatic logic [BIT_W-1:0] start_bit_f(input logic [COUNT_W-1:0] r);
        logic [BIT_W-1:0] res;
        res = '0;
        for (int b = 0; b < QUOT_W; b++) begin
            if (r[b]) begin
                res = BIT_W'(b);
            end
        end
        return res;
    endfunction

    unrk_state_t              state_reg, state_next;
    logic [COUNT_W-1:0]       n_reg, n_next;
    logic [COUNT_W-1:0]       pos_reg, pos_next;
    logic [RANK_W-1:0]        rem_reg, rem_next;
    logic [RANK_W-1:0]        fct_reg, fct_next;
    logic [QUOT_W-1:0]        quo_reg, quo_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    logic [MAX_ELEMENTS:1]    used_reg, used_next;
    out_item_t                out_reg, out_next;
    logic                     m_valid_reg, m_valid_next;

    // request checks
    logic                     bad_count;
    logic [63:0]              fact_n;
    logic                     bad_item;

    // shared compare-subtract unit
    logic [TRIAL_W-1:0]       trial;
    logic                     fits;

    // element pick from the used mask
    logic [MAX_ELEMENTS:1]    free_vec;
    logic [MAX_ELEMENTS:1]    match_vec;
    logic [ELEM_W-1:0]        pick;
    logic                     out_free;
    logic [COUNT_W-1:0]       rest;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        bad_count = (s_data.element_count == '0)
                 || (int'(s_data.element_count) > MAX_ELEMENTS);
        fact_n    = fact_f(s_data.element_count);
        bad_item  = bad_count || (s_data.rank == '0) || (64'(s_data.rank) > fact_n);
    end

    always_comb begin
        trial = TRIAL_W'(fct_reg) << bit_reg;
        fits  = TRIAL_W'(rem_reg) >= trial;
    end

    // the q-th free element: free, and exactly q free elements below it
    always_comb begin
        logic [MAX_ELEMENTS:1] below;
        pick = '0;
        for (int j = 1; j <= MAX_ELEMENTS; j++) begin
            free_vec[j] = !used_reg[j] && (COUNT_W'(j) <= n_reg);
        end
        for (int j = 1; j <= MAX_ELEMENTS; j++) begin
            below = '0;
            for (int k = 1; k < j; k++) begin
                below[k] = free_vec[k];
            end
            match_vec[j] = free_vec[j] && ($countones(below) == int'(quo_reg));
        end
        for (int j = 1; j <= MAX_ELEMENTS; j++) begin
            if (match_vec[j]) begin
                pick = pick | ELEM_W'(j);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        pos_reg  <= pos_next;
        rem_reg  <= rem_next;
        fct_reg  <= fct_next;
        quo_reg  <= quo_next;
        bit_reg  <= bit_next;
        used_reg <= used_next;
        out_reg  <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        pos_next     = pos_reg;
        rem_next     = rem_reg;
        fct_next     = fct_reg;
        quo_next     = quo_reg;
        bit_next     = bit_reg;
        used_next    = used_reg;
        out_next     = out_reg;
        rest         = n_reg - pos_reg - COUNT_W'(1);
        // drop the result once it has been taken
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // set up position 1: rank - 1 divided by (n-1)!
                    n_next    = s_data.element_count;
                    pos_next  = COUNT_W'(1);
                    rem_next  = s_data.rank - RANK_W'(1);
                    fct_next  = RANK_W'(fact_f(s_data.element_count - COUNT_W'(1)));
                    quo_next  = '0;
                    bit_next  = start_bit_f(s_data.element_count - COUNT_W'(1));
                    used_next = '0;
                    state_next = bad_item ? ST_ERR : ST_DIV;
                end
            end
            ST_DIV: begin
                // one quotient bit per cycle, highest first
                if (fits) begin
                    rem_next          = rem_reg - trial[RANK_W-1:0];
                    quo_next[bit_reg] = 1'b1;
                end
                if (bit_reg == '0) begin
                    state_next = ST_PICK;
                end else begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            ST_PICK: begin
                // hold until the output register frees up
                if (out_free) begin
                    out_next.element    = pick;
                    out_next.last       = (pos_reg == n_reg);
                    out_next.rank_error = 1'b0;
                    m_valid_next        = 1'b1;
                    used_next           = used_reg | match_vec;
                    if (pos_reg == n_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next   = pos_reg + COUNT_W'(1);
                        fct_next   = RANK_W'(fact_f(rest));
                        quo_next   = '0;
                        bit_next   = start_bit_f(rest);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    out_next.element    = '0;
                    out_next.last       = 1'b1;
                    out_next.rank_error = 1'b1;
                    m_valid_next        = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
